>>> design/monomial_order_comparator_unit_assert.svh
// Assertion macros for the monomial order comparator.
// The module that uses them supplies clk and rst_n.
`ifndef MONOMIAL_ORDER_COMPARATOR_UNIT_ASSERT_SVH
`define MONOMIAL_ORDER_COMPARATOR_UNIT_ASSERT_SVH

// Same-cycle implication.
`define MOC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define MOC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/moc_pkg.sv
package moc_pkg;

    localparam int LANE_W     = 8;
    localparam int NUM_SLOTS  = 8;
    localparam int EXP_W      = LANE_W * NUM_SLOTS;
    localparam int ORDER_W    = 3;
    localparam int VARS_W     = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    typedef enum logic [ORDER_W-1:0] {
        ORD_LEX            = 3'd0,
        ORD_REVLEX         = 3'd1,
        ORD_DEGLEX         = 3'd2,
        ORD_REVDEGLEX      = 3'd3,
        ORD_DEGREVLEX      = 3'd4,
        ORD_REV_DEGREVLEX  = 3'd5
    } order_mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ORDER_MODE  = 2'd0,
        REG_VARS_IN_USE = 2'd1
    } cfg_reg_t;

    // Per-lane compare result; unused lanes report zeros.
    typedef struct packed {
        logic              lt;
        logic              gt;
        logic [LANE_W-1:0] a_m;
        logic [LANE_W-1:0] b_m;
    } lane_res_t;

    // Merged flags of one item.
    typedef struct packed {
        logic less;
        logic eq;
        logic ldr;
        logic rdl;
    } cmp_flags_t;

endpackage

>>> design/moc_lane.sv
module moc_lane
    import moc_pkg::*;
(
    input  logic [LANE_W-1:0] a,
    input  logic [LANE_W-1:0] b,
    input  logic              in_use,
    output lane_res_t         res
);

    always_comb
    begin
        res.lt  = in_use && (a < b);
        res.gt  = in_use && (a > b);
        res.a_m = in_use ? a : '0;
        res.b_m = in_use ? b : '0;
    end

endmodule

>>> design/moc_merge.sv
module moc_merge
    import moc_pkg::*;
#(
    parameter int NLANES = 8
)
(
    input  lane_res_t            lanes [NLANES],
    input  logic [ORDER_W-1:0]   order_mode,
    output cmp_flags_t           flags
);

    localparam int DEG_W = LANE_W + $clog2(NLANES);

    logic [DEG_W-1:0] dl;
    logic [DEG_W-1:0] dr;
    logic             up_lt;
    logic             up_gt;
    logic             dn_lt;
    logic             dn_gt;
    logic             any_lt;
    logic             any_gt;
    logic             use_deg;
    logic             upward;
    logic             larger_first;
    logic             scan_less;

    // Degree sums and any-lane less/greater flags.
    always_comb
    begin
        dl     = '0;
        dr     = '0;
        any_lt = 1'b0;
        any_gt = 1'b0;
        for (int i = 0; i < NLANES; i++)
        begin
            dl     = dl + DEG_W'(lanes[i].a_m);
            dr     = dr + DEG_W'(lanes[i].b_m);
            any_lt = any_lt | lanes[i].lt;
            any_gt = any_gt | lanes[i].gt;
        end
    end

    // Lowest differing lane wins: walk downward so the last hit is the lowest.
    always_comb
    begin
        up_lt = 1'b0;
        up_gt = 1'b0;
        for (int i = NLANES - 1; i >= 0; i--)
        begin
            if (lanes[i].lt || lanes[i].gt)
            begin
                up_lt = lanes[i].lt;
                up_gt = lanes[i].gt;
            end
        end
    end

    // Highest differing lane wins; unused lanes never differ.
    always_comb
    begin
        dn_lt = 1'b0;
        dn_gt = 1'b0;
        for (int i = 0; i < NLANES; i++)
        begin
            if (lanes[i].lt || lanes[i].gt)
            begin
                dn_lt = lanes[i].lt;
                dn_gt = lanes[i].gt;
            end
        end
    end

    always_comb
    begin
        unique case (order_mode)
            ORD_REVLEX:
            begin
                use_deg = 1'b0; upward = 1'b0; larger_first = 1'b0;
            end
            ORD_DEGLEX:
            begin
                use_deg = 1'b1; upward = 1'b1; larger_first = 1'b0;
            end
            ORD_REVDEGLEX:
            begin
                use_deg = 1'b1; upward = 1'b0; larger_first = 1'b0;
            end
            ORD_DEGREVLEX:
            begin
                use_deg = 1'b1; upward = 1'b0; larger_first = 1'b1;
            end
            ORD_REV_DEGREVLEX:
            begin
                use_deg = 1'b1; upward = 1'b1; larger_first = 1'b1;
            end
            default:
            begin
                // lex, and the two unassigned codes
                use_deg = 1'b0; upward = 1'b1; larger_first = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        if (upward)
            scan_less = larger_first ? up_gt : up_lt;
        else
            scan_less = larger_first ? dn_gt : dn_lt;

        flags.less = (use_deg && (dl != dr)) ? (dl < dr) : scan_less;
        flags.eq   = !(any_lt || any_gt);
        flags.ldr  = !any_gt;
        flags.rdl  = !any_lt;
    end

endmodule

>>> design/monomial_order_comparator_unit.sv
// Monomial term-order comparator.
//
// Input channel (in_valid/in_ready) carries one item: two packed vectors of
// eight 8-bit exponents, lane one in the low byte. Output channel
// (out_valid/out_ready) returns one item of seven flags per input item, in order.
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes order_mode
// (index 0, low 3 bits) and vars_in_use (index 1, low 4 bits); other indexes
// are ignored. cfg_ready is always high. Write config only while idle.
//
// Pipeline: lane stage (MAX_VARS compare lanes, registered) then merge stage
// (degree sums, first/last differing lane, order select, registered output).
// Stages: two register stages, lane-stage register then output register; an item
// moves on, raising out_valid, whenever the output register is free.
// Throughput: one item per cycle, sustained, while out_ready stays high.
// When the receiver stalls, the output register holds its item and the lane
// stage holds one more; in_ready drops only when both are full.
// Reset: pipeline empties, order_mode = lex, vars_in_use = 8. No memories,
// so there is no clearing pass.
module monomial_order_comparator_unit
    import moc_pkg::*;
#(
    parameter int MAX_VARS = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [EXP_W-1:0]      left_exponents,
    input  logic [EXP_W-1:0]      right_exponents,

    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  is_less,
    output logic                  is_less_or_equal,
    output logic                  is_greater,
    output logic                  is_greater_or_equal,
    output logic                  is_equal,
    output logic                  left_divides_right,
    output logic                  right_divides_left
);

    // Config registers
    logic [ORDER_W-1:0] order_mode_reg;
    logic [VARS_W-1:0]  vars_in_use_reg;

    // Effective lane count, clamped to MAX_VARS
    logic [VARS_W-1:0]  n_eff;
    logic [MAX_VARS-1:0] lane_in_use;

    lane_res_t lane_res    [MAX_VARS];
    lane_res_t s1_lane_reg [MAX_VARS];
    cmp_flags_t merged;
    cmp_flags_t out_flags_reg;

    logic s1_valid_reg;
    logic s1_valid_next;
    logic out_valid_reg;
    logic out_valid_next;

    logic in_fire;
    logic out_take;
    logic out_free;
    logic s1_take;

    //------------------------------------------------------------------
    // Config port: always ready, one register per assigned index.
    //------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_mode_reg  <= ORD_LEX;
            vars_in_use_reg <= VARS_W'(NUM_SLOTS);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_ORDER_MODE:  order_mode_reg  <= cfg_data[ORDER_W-1:0];
                REG_VARS_IN_USE: vars_in_use_reg <= cfg_data[VARS_W-1:0];
                default:         ;
            endcase
        end
    end

    assign n_eff = (vars_in_use_reg > VARS_W'(MAX_VARS)) ? VARS_W'(MAX_VARS)
                                                         : vars_in_use_reg;

    //------------------------------------------------------------------
    // Handshake: output register frees when taken; the lane stage moves
    // into it whenever it is free.
    //------------------------------------------------------------------
    assign out_take = out_valid_reg && out_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign s1_take  = s1_valid_reg && out_free;
    assign in_ready = !s1_valid_reg || out_free;
    assign in_fire  = in_valid && in_ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_fire)
            s1_valid_next = 1'b1;
        else if (s1_take)
            s1_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (s1_take)
            out_valid_next = 1'b1;
        else if (out_take)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    //------------------------------------------------------------------
    // Lane stage: one comparator per variable.
    //------------------------------------------------------------------
    for (genvar i = 0; i < MAX_VARS; i++)
    begin : g_lane
        assign lane_in_use[i] = (VARS_W'(i) < n_eff);

        moc_lane u_lane (
            .a      (left_exponents[i*LANE_W +: LANE_W]),
            .b      (right_exponents[i*LANE_W +: LANE_W]),
            .in_use (lane_in_use[i]),
            .res    (lane_res[i])
        );
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
            s1_lane_reg <= lane_res;
    end

    //------------------------------------------------------------------
    // Merge stage: degrees, scan direction, order select.
    //------------------------------------------------------------------
    moc_merge #(
        .NLANES (MAX_VARS)
    ) u_merge (
        .lanes      (s1_lane_reg),
        .order_mode (order_mode_reg),
        .flags      (merged)
    );

    always_ff @(posedge clk)
    begin
        if (s1_take)
            out_flags_reg <= merged;
    end

    //------------------------------------------------------------------
    // Outputs
    //------------------------------------------------------------------
    assign out_valid           = out_valid_reg;
    assign is_less             = out_flags_reg.less;
    assign is_less_or_equal    = out_flags_reg.less || out_flags_reg.eq;
    assign is_greater          = !(out_flags_reg.less || out_flags_reg.eq);
    assign is_greater_or_equal = !out_flags_reg.less;
    assign is_equal            = out_flags_reg.eq;
    assign left_divides_right  = out_flags_reg.ldr;
    assign right_divides_left  = out_flags_reg.rdl;

    //------------------------------------------------------------------
    // Assertions
    //------------------------------------------------------------------
    `include "monomial_order_comparator_unit_assert.svh"

    // Equal vectors divide each other and never order strictly.
    `MOC_ASSERT_NOW(a_equal_flags, out_valid && is_equal,
        left_divides_right && right_divides_left && !is_less, "equal item has bad flags")

    // Both stages full and stalled: no new item may enter.
    `MOC_ASSERT_NOW(a_full_stall, s1_valid_reg && out_valid_reg && !out_ready,
        !in_ready, "item accepted into full pipeline")

    // A lane-stage item that cannot move must still be there next cycle.
    `MOC_ASSERT_NEXT(a_s1_hold, s1_valid_reg && !s1_take,
        s1_valid_reg, "lane stage item dropped")

endmodule
